/* sv/pidfd_pkg.sv */
// Shared types and codes for the filtered-derivative PID controller.
package pidfd_pkg;

    localparam int CMD_W      = 2;
    localparam int FIELD_W    = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_INT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_TIME = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_TAU  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_EN    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_INT_LIMITS  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_LIMITS  = 3'd7;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

endpackage

/* sv/pid_controller_filtered_derivative_top.sv */
// PID controller with filtered derivative on measurement, signed fixed point.
// An update runs the integral step, then alpha, rate and filter steps when sample time and filter tau
// are both nonzero, then P, I and D; clear commands go straight to output. Default parameters give Q16.16.
// One request at a time; the restoring divide yields one quotient bit per cycle.
// A finished result waits in the output register while the next request is taken.
// Synchronous active-low reset clears configuration, state, integrator, filter, last measurement and held output.
module pid_controller_filtered_derivative_top #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [pidfd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [pidfd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [pidfd_pkg::CMD_W-1:0]             i_command,
    input  logic signed [pidfd_pkg::FIELD_W-1:0]    i_measurement,
    input  logic signed [pidfd_pkg::FIELD_W-1:0]    i_set_point,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [pidfd_pkg::FIELD_W-1:0]    o_control_output
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int EW = ((W > 32) ? W : 32) + 2;

    localparam logic signed [EW-1:0] E_WMAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] E_WMIN = ~E_WMAX;
    localparam logic signed [W-1:0]  ONE_Q  =
        (F < W - 1) ? (W'(1) << F) : E_WMAX[W-1:0];

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_ERR    = 8'b00000010,
        S_ISSUE  = 8'b00000100,
        S_WAIT   = 8'b00001000,
        S_ICLAMP = 8'b00010000,
        S_USAT   = 8'b00100000,
        S_UCLAMP = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    typedef enum logic [7:0] {
        P_INT   = 8'b00000001,
        P_ALPHA = 8'b00000010,
        P_RATE  = 8'b00000100,
        P_FILT1 = 8'b00001000,
        P_FILT2 = 8'b00010000,
        P_PROP  = 8'b00100000,
        P_INTEG = 8'b01000000,
        P_DERIV = 8'b10000000
    } t_step;

    function automatic logic signed [W-1:0] f_sat(input logic signed [EW-1:0] v);
        if (v > E_WMAX) begin
            return E_WMAX[W-1:0];
        end else if (v < E_WMIN) begin
            return E_WMIN[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [EW-1:0] f_sx32(input logic [31:0] v);
        return {{(EW-32){v[31]}}, v};
    endfunction

    function automatic logic signed [EW-1:0] f_sxw(input logic signed [W-1:0] v);
        return {{(EW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [W-1:0] f_clamp(input logic signed [W-1:0] v,
                                                    input logic [63:0] lims);
        logic signed [W-1:0] hi;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] t;
        hi = f_sat(f_sx32(lims[63:32]));
        lo = f_sat(f_sx32(lims[31:0]));
        t  = (v > hi) ? hi : v;
        return (t < lo) ? lo : t;
    endfunction

    // configuration
    logic signed [W-1:0] r_gain_p;
    logic signed [W-1:0] r_gain_i;
    logic signed [W-1:0] r_gain_d;
    logic [30:0]         r_sample_time;
    logic [30:0]         r_filter_tau;
    logic [1:0]          r_limit_en;
    logic [63:0]         r_int_lim;
    logic [63:0]         r_out_lim;

    // control
    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_out_valid;
    logic [pidfd_pkg::FIELD_W-1:0] r_out_data;

    // loop state
    logic signed [W-1:0] r_int;
    logic signed [W-1:0] r_filt;
    logic signed [W-1:0] r_last;
    logic signed [W-1:0] r_held;

    // working values
    logic signed [W-1:0]  r_meas;
    logic signed [W-1:0]  r_sp;
    logic signed [W-1:0]  r_err;
    logic signed [W-1:0]  r_alpha;
    logic signed [W-1:0]  r_rate;
    logic signed [W-1:0]  r_tmp;
    logic signed [EW-1:0] r_sum;

    logic                 accept;
    logic                 out_free;
    logic                 deriv_en;
    logic [31:0]          t_sum_raw;
    logic signed [W-1:0]  tq;
    logic signed [W-1:0]  t_sum;
    logic signed [EW-1:0] held_ext;

    pidfd_pkg::t_alu_ctl  alu_ctl;
    logic signed [W-1:0]  alu_a;
    logic signed [W-1:0]  alu_b;
    logic                 alu_done;
    logic signed [W-1:0]  alu_res;

    assign accept    = i_in_valid & o_in_ready;
    assign out_free  = ~r_out_valid | i_out_ready;
    assign deriv_en  = (|r_sample_time) & (|r_filter_tau);
    assign t_sum_raw = {1'b0, r_sample_time} + {1'b0, r_filter_tau};
    assign tq        = f_sat({{(EW-31){1'b0}}, r_sample_time});
    assign t_sum     = f_sat({{(EW-32){1'b0}}, t_sum_raw});
    assign held_ext  = f_sxw(r_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_sample_time <= '0;
            r_filter_tau  <= '0;
            r_limit_en    <= '0;
            r_int_lim     <= '0;
            r_out_lim     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pidfd_pkg::CFG_GAIN_P:      r_gain_p <= f_sat(f_sx32(i_cfg_data[31:0]));
                pidfd_pkg::CFG_GAIN_I:      r_gain_i <= f_sat(f_sx32(i_cfg_data[31:0]));
                pidfd_pkg::CFG_GAIN_D:      r_gain_d <= f_sat(f_sx32(i_cfg_data[31:0]));
                pidfd_pkg::CFG_SAMPLE_TIME: r_sample_time <= i_cfg_data[30:0];
                pidfd_pkg::CFG_FILTER_TAU:  r_filter_tau <= i_cfg_data[30:0];
                pidfd_pkg::CFG_LIMIT_EN:    r_limit_en <= i_cfg_data[1:0];
                pidfd_pkg::CFG_INT_LIMITS:  r_int_lim <= i_cfg_data;
                pidfd_pkg::CFG_OUT_LIMITS:  r_out_lim <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        alu_ctl.start = (r_state == S_ISSUE);
        alu_ctl.op    = pidfd_pkg::ALU_MUL;
        alu_a         = r_err;
        alu_b         = tq;
        unique case (r_step)
            P_INT: begin
                alu_a = r_err;
                alu_b = tq;
            end
            P_ALPHA: begin
                alu_ctl.op = pidfd_pkg::ALU_DIV;
                alu_a      = tq;
                alu_b      = t_sum;
            end
            P_RATE: begin
                alu_ctl.op = pidfd_pkg::ALU_DIV;
                alu_a      = f_sat(f_sxw(r_meas) - f_sxw(r_last));
                alu_b      = tq;
            end
            P_FILT1: begin
                alu_a = r_alpha;
                alu_b = r_rate;
            end
            P_FILT2: begin
                alu_a = f_sat(f_sxw(ONE_Q) - f_sxw(r_alpha));
                alu_b = r_filt;
            end
            P_PROP: begin
                alu_a = r_gain_p;
                alu_b = r_err;
            end
            P_INTEG: begin
                alu_a = r_gain_i;
                alu_b = r_int;
            end
            P_DERIV: begin
                alu_a = r_gain_d;
                alu_b = r_filt;
            end
            default: begin
            end
        endcase
    end

    pidfd_alu #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_opa   (alu_a),
        .i_opb   (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_command == pidfd_pkg::CMD_UPDATE) ? S_ERR : S_DONE;
                end
            end
            S_ERR: begin
                n_step  = P_INT;
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (alu_done) begin
                    n_state = S_ISSUE;
                    unique case (r_step)
                        P_INT:   n_state = S_ICLAMP;
                        P_ALPHA: n_step = P_RATE;
                        P_RATE:  n_step = P_FILT1;
                        P_FILT1: n_step = P_FILT2;
                        P_FILT2: n_step = P_PROP;
                        P_PROP:  n_step = P_INTEG;
                        P_INTEG: n_step = P_DERIV;
                        P_DERIV: n_state = S_USAT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ICLAMP: begin
                n_step  = deriv_en ? P_ALPHA : P_PROP;
                n_state = S_ISSUE;
            end
            S_USAT: begin
                n_state = S_UCLAMP;
            end
            S_UCLAMP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= P_INT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_data <= held_ext[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int  <= '0;
            r_filt <= '0;
            r_last <= '0;
            r_held <= '0;
        end else begin
            if (accept) begin
                if (i_command == pidfd_pkg::CMD_CLEAR_ALL) begin
                    r_int  <= '0;
                    r_filt <= '0;
                    r_last <= '0;
                    r_held <= '0;
                end else if (i_command == pidfd_pkg::CMD_CLEAR_INT) begin
                    r_int <= '0;
                end
            end
            if (r_state == S_WAIT && alu_done) begin
                if (r_step == P_INT) begin
                    r_int <= f_sat(f_sxw(r_int) + f_sxw(alu_res));
                end
                if (r_step == P_FILT2) begin
                    r_filt <= f_sat(f_sxw(r_tmp) + f_sxw(alu_res));
                end
            end
            if (r_state == S_ICLAMP && r_limit_en[0]) begin
                r_int <= f_clamp(r_int, r_int_lim);
            end
            if (r_state == S_USAT) begin
                r_held <= f_sat(r_sum);
            end
            if (r_state == S_UCLAMP) begin
                if (r_limit_en[1]) begin
                    r_held <= f_clamp(r_held, r_out_lim);
                end
                r_last <= r_meas;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meas <= f_sat(f_sx32(i_measurement));
            r_sp   <= f_sat(f_sx32(i_set_point));
        end
        if (r_state == S_ERR) begin
            r_err <= f_sat(f_sxw(r_sp) - f_sxw(r_meas));
        end
        if (r_state == S_WAIT && alu_done) begin
            unique case (r_step)
                P_ALPHA: r_alpha <= alu_res;
                P_RATE:  r_rate <= alu_res;
                P_FILT1: r_tmp <= alu_res;
                P_PROP:  r_sum <= f_sxw(alu_res);
                P_INTEG: r_sum <= r_sum + f_sxw(alu_res);
                P_DERIV: r_sum <= r_sum - f_sxw(alu_res);
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_control_output = r_out_data;

endmodule

/* sv/pidfd_alu.sv */
// Shared saturating fixed-point multiply and divide unit, multi-cycle.
module pidfd_alu #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pidfd_pkg::t_alu_ctl          i_ctl,
    input  logic signed [WORD_WIDTH-1:0] i_opa,
    input  logic signed [WORD_WIDTH-1:0] i_opb,
    output logic                         o_done,
    output logic signed [WORD_WIDTH-1:0] o_res
);

    localparam int W    = WORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = 16;
    localparam int ND   = (W + DW - 1) / DW;
    localparam int BW   = ND * DW;
    localparam int PW   = W + BW;
    localparam int QW   = W + F;
    localparam int MMW  = PW - F;
    localparam int CMPW = (MMW > QW) ? MMW : QW;
    localparam int NIT  = (QW > ND) ? QW : ND;
    localparam int CW   = $clog2(NIT + 1);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } t_astate;

    function automatic logic [W-1:0] f_mag(input logic signed [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    t_astate             r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_done;
    pidfd_pkg::t_alu_op  r_op;
    logic                r_neg;
    logic [W-1:0]        r_ua;
    logic [BW-1:0]       r_mpl;
    logic [PW-1:0]       r_acc;
    logic [W-1:0]        r_rem;
    logic [QW-1:0]       r_quo;
    logic signed [W-1:0] r_res;

    logic [W+DW-1:0] part;
    logic [PW-1:0]   acc_next;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic            fits;
    logic [W-1:0]    lim;
    logic [CMPW-1:0] mag_sel;
    logic [W-1:0]    sat_mag;
    logic [W-1:0]    res_fin;

    assign part     = r_ua * r_mpl[BW-1 -: DW];
    assign acc_next = {r_acc[PW-DW-1:0], {DW{1'b0}}} + PW'(part);
    assign trial    = {r_rem, r_quo[QW-1]};
    assign fits     = trial >= {1'b0, r_ua};
    assign diff     = trial - {1'b0, r_ua};
    assign lim      = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign mag_sel  = (r_op == pidfd_pkg::ALU_MUL) ? CMPW'(r_acc[PW-1:F]) : CMPW'(r_quo);
    assign sat_mag  = (mag_sel > CMPW'(lim)) ? lim : mag_sel[W-1:0];
    assign res_fin  = r_neg ? (~sat_mag + 1'b1) : sat_mag;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            A_IDLE: begin
                if (i_ctl.start) begin
                    if (i_ctl.op == pidfd_pkg::ALU_MUL) begin
                        n_state = A_MUL;
                        n_cnt   = CW'(ND);
                    end else begin
                        n_state = A_DIV;
                        n_cnt   = CW'(QW);
                    end
                end
            end
            A_MUL, A_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = A_FIN;
                end
            end
            A_FIN: begin
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == A_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_ctl.start) begin
                    r_op  <= i_ctl.op;
                    r_neg <= i_opa[W-1] ^ i_opb[W-1];
                    if (i_ctl.op == pidfd_pkg::ALU_MUL) begin
                        r_ua  <= f_mag(i_opa);
                        r_mpl <= BW'(f_mag(i_opb));
                        r_acc <= '0;
                    end else begin
                        r_ua  <= f_mag(i_opb);
                        r_quo <= {f_mag(i_opa), {F{1'b0}}};
                        r_rem <= '0;
                    end
                end
            end
            A_MUL: begin
                r_acc <= acc_next;
                r_mpl <= {r_mpl[BW-DW-1:0], {DW{1'b0}}};
            end
            A_DIV: begin
                r_rem <= fits ? diff[W-1:0] : trial[W-1:0];
                r_quo <= {r_quo[QW-2:0], fits};
            end
            A_FIN: begin
                r_res <= res_fin;
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
